FILE: hdl/simint_pkg.sv
// ----------------------------------------------------------------------------
// simint_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// streaming Simpson integrator.
// ----------------------------------------------------------------------------
package simint_pkg;

  // field widths
  localparam int SAMPLE_BITS = 32;
  localparam int COUNT_BITS  = 16;
  localparam int BOUND_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_BITS    = 64;

  // accumulator: pair sum of up to 2^(COUNT_BITS-1) pairs, then 2S + 3T
  localparam int ACC_BITS  = SAMPLE_BITS + COUNT_BITS + 4;
  // magnitude is multiplied in two halves
  localparam int HALF_BITS = (ACC_BITS + 1) / 2;
  localparam int PP_BITS   = BOUND_BITS + HALF_BITS;
  localparam int PROD_BITS = BOUND_BITS + 2 * HALF_BITS;
  // dividend after dropping the fraction bits, divisor is 6*N
  localparam int QUO_BITS  = PROD_BITS - FRAC_BITS;
  localparam int QEXT_BITS = (QUO_BITS > OUT_BITS) ? QUO_BITS : OUT_BITS + 1;
  localparam int DVS_BITS  = COUNT_BITS + 3;
  localparam int DIV_CNT_BITS = $clog2(QUO_BITS);

  // configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_X_START,
    REG_X_END,
    REG_INTERVAL_COUNT
  } reg_index_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic prep;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic div_step;
    logic out_load;
  } simint_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } simint_status_t;

endpackage

FILE: hdl/simint_regs.sv
// ----------------------------------------------------------------------------
// simint_regs
// APB-style register file holding the integration bounds and interval count.
// ----------------------------------------------------------------------------
module simint_regs (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [simint_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [simint_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [simint_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                     pready,
  output logic signed [simint_pkg::BOUND_BITS-1:0] x_start,
  output logic signed [simint_pkg::BOUND_BITS-1:0] x_end,
  output logic [simint_pkg::COUNT_BITS-1:0]        interval_count
);
  import simint_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_ADDR_BITS-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      x_start        <= '0;
      x_end          <= BOUND_BITS'(65536);
      interval_count <= COUNT_BITS'(2);
    end else if (wr_en) begin
      case (reg_sel)
        REG_X_START:        x_start        <= pwdata[BOUND_BITS-1:0];
        REG_X_END:          x_end          <= pwdata[BOUND_BITS-1:0];
        REG_INTERVAL_COUNT: interval_count <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_X_START:        prdata = CFG_DATA_BITS'(x_start);
      REG_X_END:          prdata = CFG_DATA_BITS'(x_end);
      REG_INTERVAL_COUNT: prdata = CFG_DATA_BITS'(interval_count);
      default:            prdata = '0;
    endcase
  end

endmodule

FILE: hdl/simint_ctrl.sv
// ----------------------------------------------------------------------------
// simint_ctrl
// Sequencer: accumulates samples, then steps the scale multiply, the
// restoring divide and the output register load.
// ----------------------------------------------------------------------------
module simint_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_stall,
  input  simint_pkg::simint_status_t status,
  output logic                       in_stall,
  output logic                       out_valid,
  output simint_pkg::simint_cmd_t    cmd
);
  import simint_pkg::*;

  typedef enum logic [2:0] {
    ACCUM,
    PREP,
    MUL_LO,
    MUL_HI,
    MUL_SUM,
    DIV,
    HOLD
  } state_t;

  state_t                  state;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  // samples flow only while accumulating
  assign in_stall = (state != ACCUM);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.take     = in_valid && (state == ACCUM);
    cmd.prep     = (state == PREP);
    cmd.mul_lo   = (state == MUL_LO);
    cmd.mul_hi   = (state == MUL_HI);
    cmd.mul_sum  = (state == MUL_SUM);
    cmd.div_step = (state == DIV);
    cmd.out_load = (state == HOLD) && (!out_valid || !out_stall);
  end

  // state, divide count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ACCUM;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ACCUM:   if (cmd.take && status.last) state <= PREP;
        PREP:    state <= MUL_LO;
        MUL_LO:  state <= MUL_HI;
        MUL_HI:  state <= MUL_SUM;
        MUL_SUM: begin
          div_cnt <= DIV_CNT_BITS'(QUO_BITS - 1);
          state   <= DIV;
        end
        DIV: begin
          if (div_cnt == '0) state <= HOLD;
          else div_cnt <= div_cnt - 1'b1;
        end
        HOLD:    if (cmd.out_load) state <= ACCUM;
        default: state <= ACCUM;
      endcase

      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/simint_dp.sv
// ----------------------------------------------------------------------------
// simint_dp
// Datapath: sample history and pair sum, trapezoid term, split magnitude
// multiply, bit-serial restoring divide and output saturation.
// ----------------------------------------------------------------------------
module simint_dp (
  input  logic                                      clk,
  input  logic                                      rst,
  input  simint_pkg::simint_cmd_t                   cmd,
  input  logic signed [simint_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [simint_pkg::BOUND_BITS-1:0]  x_start,
  input  logic signed [simint_pkg::BOUND_BITS-1:0]  x_end,
  input  logic [simint_pkg::COUNT_BITS-1:0]         interval_count,
  output simint_pkg::simint_status_t                status,
  output logic signed [simint_pkg::OUT_BITS-1:0]    integral,
  output logic                                      saturated
);
  import simint_pkg::*;

  localparam int TERM_BITS = SAMPLE_BITS + 3;

  // run state
  logic signed [ACC_BITS-1:0]    pair_sum;
  logic signed [SAMPLE_BITS-1:0] prior_sample;
  logic signed [SAMPLE_BITS-1:0] older_sample;
  logic [COUNT_BITS-1:0]         sample_index;
  logic signed [SAMPLE_BITS:0]   trap;

  // scale and divide registers
  logic [BOUND_BITS-1:0]  md;
  logic [2*HALF_BITS-1:0] ma;
  logic                   neg;
  logic [DVS_BITS-1:0]    dvs;
  logic [PP_BITS-1:0]     pp;
  logic [PP_BITS-1:0]     prod_lo;
  logic [QUO_BITS-1:0]    quo;
  logic [DVS_BITS-1:0]    rem;

  logic [COUNT_BITS-1:0]         n_eff;
  logic                          pair_en;
  logic signed [TERM_BITS-1:0]   pair_term;
  logic signed [ACC_BITS-1:0]    pair_next;
  logic signed [SAMPLE_BITS:0]   trap_next;
  logic signed [ACC_BITS-1:0]    acc;
  logic                          acc_neg;
  logic [ACC_BITS-1:0]           acc_mag;
  logic signed [BOUND_BITS:0]    diff;
  logic [BOUND_BITS:0]           diff_abs;
  logic [HALF_BITS-1:0]          ma_half;
  logic [PROD_BITS-1:0]          prod_sum;
  logic [DVS_BITS:0]             rem_shift;
  logic [DVS_BITS:0]             rem_trial;
  logic                          quo_bit;
  logic [QEXT_BITS-1:0]          qx;
  logic                          high_zero;
  logic                          is_min;
  logic signed [OUT_BITS-1:0]    res;
  logic                          res_sat;

  // run bookkeeping, a zero count acts as one interval
  assign n_eff       = (interval_count == '0) ? COUNT_BITS'(1) : interval_count;
  assign status.last = (sample_index >= n_eff);
  assign pair_en     = (sample_index >= COUNT_BITS'(2)) && !sample_index[0]
                       && (sample_index <= n_eff);

  // pair term F[k-2] + 4F[k-1] + F[k]
  assign pair_term = TERM_BITS'(older_sample) + (TERM_BITS'(prior_sample) <<< 2)
                     + TERM_BITS'(sample);
  assign pair_next = pair_en ? pair_sum + ACC_BITS'(pair_term) : pair_sum;

  // trapezoid term for an odd count
  assign trap_next = n_eff[0] ? (SAMPLE_BITS+1)'(prior_sample) + (SAMPLE_BITS+1)'(sample)
                              : '0;

  // 2S + 3T and its magnitude
  assign acc     = (pair_sum <<< 1) + ACC_BITS'(trap) + (ACC_BITS'(trap) <<< 1);
  assign acc_neg = acc[ACC_BITS-1];
  assign acc_mag = acc_neg ? ACC_BITS'(-acc) : ACC_BITS'(acc);

  // interval width and its magnitude
  assign diff     = (BOUND_BITS+1)'(x_end) - (BOUND_BITS+1)'(x_start);
  assign diff_abs = diff[BOUND_BITS] ? (BOUND_BITS+1)'(-diff) : (BOUND_BITS+1)'(diff);

  // one half of the accumulator magnitude per multiply step
  assign ma_half  = cmd.mul_hi ? ma[2*HALF_BITS-1:HALF_BITS] : ma[HALF_BITS-1:0];
  assign prod_sum = PROD_BITS'(prod_lo) + (PROD_BITS'(pp) << HALF_BITS);

  // restoring divide step
  assign rem_shift = {rem, quo[QUO_BITS-1]};
  assign quo_bit   = (rem_shift >= {1'b0, dvs});
  assign rem_trial = rem_shift - {1'b0, dvs};

  // sign and saturation of the quotient
  assign qx        = QEXT_BITS'(quo);
  assign high_zero = (qx[QEXT_BITS-1:OUT_BITS-1] == '0);
  assign is_min    = (qx == (QEXT_BITS'(1) << (OUT_BITS - 1)));

  always_comb begin
    if (neg) begin
      if (high_zero || is_min) begin
        res     = -$signed(qx[OUT_BITS-1:0]);
        res_sat = 1'b0;
      end else begin
        res     = {1'b1, {(OUT_BITS-1){1'b0}}};
        res_sat = 1'b1;
      end
    end else begin
      if (high_zero) begin
        res     = $signed(qx[OUT_BITS-1:0]);
        res_sat = 1'b0;
      end else begin
        res     = {1'b0, {(OUT_BITS-1){1'b1}}};
        res_sat = 1'b1;
      end
    end
  end

  // run state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sum     <= '0;
      prior_sample <= '0;
      older_sample <= '0;
      sample_index <= '0;
      trap         <= '0;
    end else if (cmd.take) begin
      pair_sum <= pair_next;
      if (status.last) begin
        trap         <= trap_next;
        prior_sample <= '0;
        older_sample <= '0;
        sample_index <= '0;
      end else begin
        older_sample <= prior_sample;
        prior_sample <= sample;
        sample_index <= sample_index + 1'b1;
      end
    end else if (cmd.prep) begin
      pair_sum <= '0;
    end
  end

  // scale, divide and output registers
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ma  <= (2*HALF_BITS)'(acc_mag);
      md  <= diff_abs[BOUND_BITS-1:0];
      neg <= acc_neg ^ diff[BOUND_BITS];
      dvs <= (DVS_BITS'(n_eff) << 2) + (DVS_BITS'(n_eff) << 1);
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      pp <= PP_BITS'(md) * PP_BITS'(ma_half);
    end
    if (cmd.mul_hi) begin
      prod_lo <= pp;
    end
    if (cmd.mul_sum) begin
      quo <= prod_sum[PROD_BITS-1:FRAC_BITS];
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[QUO_BITS-2:0], quo_bit};
      rem <= quo_bit ? rem_trial[DVS_BITS-1:0] : rem_shift[DVS_BITS-1:0];
    end
    if (cmd.out_load) begin
      integral  <= res;
      saturated <= res_sat;
    end
  end

endmodule

FILE: hdl/simpson_integrator.sv
// ----------------------------------------------------------------------------
// simpson_integrator
// Streaming composite Simpson integrator in Q16.16 fixed point.
//
// Samples F0..FN enter on the sample channel (in_valid / in_stall), one beat
// per cycle while a run accumulates. The beat carrying sample N closes the
// run; one beat with the saturated integral then leaves on the result channel
// (out_valid / out_stall). Other samples give no result.
// Bounds and N must be set through the APB-style port only while the block is
// idle; the block itself does not enforce this. After the closing sample beat
// the sequencer forms 2S+3T, runs the split 32x26 multiply, retires the 68
// quotient bits one per step in the restoring divider by 6N, and loads the
// output register. in_stall stays high after the closing beat until that load,
// so no samples of the next run are taken before it.
// A stalled result sits in the output register; the next run accumulates
// meanwhile and its closing result waits until the register is free.
// Reset clears the run state and the channels; bounds return to 0 and 1.0,
// N returns to 2.
// ----------------------------------------------------------------------------
module simpson_integrator (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [simint_pkg::CFG_ADDR_BITS-1:0]      paddr,
  input  logic [simint_pkg::CFG_DATA_BITS-1:0]      pwdata,
  output logic [simint_pkg::CFG_DATA_BITS-1:0]      prdata,
  output logic                                      pready,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [simint_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [simint_pkg::OUT_BITS-1:0]    integral,
  output logic                                      saturated
);
  import simint_pkg::*;

  logic signed [BOUND_BITS-1:0] x_start;
  logic signed [BOUND_BITS-1:0] x_end;
  logic [COUNT_BITS-1:0]        interval_count;
  simint_cmd_t                  cmd;
  simint_status_t               status;

  // configuration registers
  simint_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .x_start        (x_start),
    .x_end          (x_end),
    .interval_count (interval_count)
  );

  // sequencer
  simint_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // arithmetic
  simint_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sample         (sample),
    .x_start        (x_start),
    .x_end          (x_end),
    .interval_count (interval_count),
    .status         (status),
    .integral       (integral),
    .saturated      (saturated)
  );

endmodule
